// ===== rtl/sha256s_pkg.sv =====
// -----------------------------------------------------------------------------
// sha256s_pkg
// Shared types and constants for the SHA-256 stream hasher: word types, the
// initial hash value, the round constants and the round unit control struct.
// -----------------------------------------------------------------------------
package sha256s_pkg;

	typedef logic [31:0] word_t;
	typedef word_t hash_t [8];

	localparam int RoundCount = 64;
	localparam int BlockBytes = 64;
	localparam int LenStart   = 56;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam hash_t INIT_HASH = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_KEY [RoundCount] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Control from the sequencer to the round unit.
	typedef struct packed {
		logic       shift;     // shift one byte into the block window
		logic [7:0] byte_val;  // byte to shift in
		logic       load;      // copy the hash words into the round variables
		logic       round;     // run one compression round
		logic [5:0] rnd;       // round index, selects the round constant
	} core_ctrl_t;

endpackage

// ===== rtl/sha256_stream_hasher_top.sv =====
// -----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream, one byte per request, eight digest words out.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid / byte_stall): each request carries data_byte
//   when has_byte is set, and is_last ends the message (a byte and the end
//   may come together; an end alone is allowed, also for an empty message).
//   Output channel (digest_valid / digest_stall): after an end, eight
//   requests carry digest words 0..7 in order, last_word set on word 7.
// Timing:
//   A byte that does not complete a 64-byte block leaves the sequencer idle.
//   The byte that completes a block starts the shared round unit: 64 rounds
//   at one per cycle, then a fold into the hash words. An end pads one byte
//   per cycle up to the block boundary (one or two blocks, each followed by
//   the rounds and the fold), then loads one digest word per cycle while the
//   output is not stalled. byte_stall is high whenever the sequencer is not
//   idle.
// Reset: arst_n clears the sequencer, byte count and length, and sets the
//   hash words to the initial value; the window needs no reset.
// Stall: a stalled digest word holds in its output register; the next word
//   loads as soon as the current one is taken. Input is taken again while
//   the eighth word still waits.
// -----------------------------------------------------------------------------
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_FOLD  = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [5:0] CNT_LAST = 6'(sha256s_pkg::BlockBytes - 1);
	localparam logic [5:0] CNT_LEN  = 6'(sha256s_pkg::LenStart);
	localparam logic [5:0] RND_LAST = 6'(sha256s_pkg::RoundCount - 1);

	logic [2:0]  state_q;
	logic [5:0]  cnt_q;        // bytes in the current block
	logic [60:0] len_q;        // message length in bytes, bit length is len_q * 8
	logic [5:0]  rnd_q;
	logic        pend_q;       // an end was taken, finish still running
	logic        pad_first_q;  // next pad byte is the 0x80 mark
	logic        final_blk_q;  // the padded block being filled carries the length
	logic        blk_fin_q;    // the block in the round unit is the last one
	logic [2:0]  ld_q;         // next digest word to load

	sha256s_pkg::hash_t h_q;
	sha256s_pkg::hash_t vars;

	logic        dv_q;
	logic [31:0] dw_q;
	logic [2:0]  wi_q;
	logic        lw_q;

	logic        accept;
	logic        take_byte;
	logic        fin_now;
	logic [63:0] bit_len;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic        dload;

	sha256s_pkg::core_ctrl_t ctrl;

	assign byte_stall = (state_q != ST_IDLE);
	assign accept     = byte_valid && !byte_stall;
	assign take_byte  = accept && has_byte;

	// On the first pad byte decide whether the length still fits this block.
	assign fin_now  = pad_first_q ? (cnt_q < CNT_LEN) : final_blk_q;
	assign bit_len  = {len_q, 3'b000};
	assign len_byte = bit_len[{~cnt_q[2:0], 3'b000} +: 8];
	assign pad_byte = pad_first_q ? sha256s_pkg::PAD_MARK
		: ((fin_now && (cnt_q >= CNT_LEN)) ? len_byte : 8'h00);

	always_comb begin
		ctrl.shift    = take_byte || (state_q == ST_PAD);
		ctrl.byte_val = (state_q == ST_PAD) ? pad_byte : data_byte;
		ctrl.load     = (cnt_q == CNT_LAST) && (take_byte || (state_q == ST_PAD));
		ctrl.round    = (state_q == ST_ROUND);
		ctrl.rnd      = rnd_q;
	end

	sha256s_core u_core (
		.clk  (clk),
		.ctrl (ctrl),
		.hash (h_q),
		.vars (vars)
	);

	// Load a digest word when the output register is empty or being drained.
	assign dload = (state_q == ST_OUT) && (!dv_q || !digest_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			len_q       <= '0;
			rnd_q       <= '0;
			pend_q      <= 1'b0;
			pad_first_q <= 1'b0;
			final_blk_q <= 1'b0;
			blk_fin_q   <= 1'b0;
			ld_q        <= '0;
			h_q         <= sha256s_pkg::INIT_HASH;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (has_byte) begin
							cnt_q <= cnt_q + 6'd1;
							len_q <= len_q + 61'd1;
						end
						if (is_last) begin
							pend_q      <= 1'b1;
							pad_first_q <= 1'b1;
						end
						// A full block compresses first; the finish follows it.
						if (has_byte && (cnt_q == CNT_LAST)) begin
							state_q   <= ST_ROUND;
							rnd_q     <= '0;
							blk_fin_q <= 1'b0;
						end else if (is_last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == RND_LAST) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + vars[i];
					end
					// After a spilled block the next padded block takes the length.
					final_blk_q <= 1'b1;
					if (blk_fin_q) begin
						state_q <= ST_OUT;
						ld_q    <= '0;
					end else if (pend_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					cnt_q       <= cnt_q + 6'd1;
					pad_first_q <= 1'b0;
					final_blk_q <= fin_now;
					if (cnt_q == CNT_LAST) begin
						state_q   <= ST_ROUND;
						rnd_q     <= '0;
						blk_fin_q <= fin_now;
					end
				end
				ST_OUT: begin
					if (dload) begin
						ld_q <= ld_q + 3'd1;
						// Last word is in the output register: restart the hash.
						if (ld_q == 3'd7) begin
							state_q <= ST_IDLE;
							h_q     <= sha256s_pkg::INIT_HASH;
							len_q   <= '0;
							pend_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: hold while stalled, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= 1'b0;
		end else if (dload) begin
			dv_q <= 1'b1;
		end else if (!digest_stall) begin
			dv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dload) begin
			dw_q <= h_q[ld_q];
			wi_q <= ld_q;
			lw_q <= (ld_q == 3'd7);
		end
	end

	assign digest_valid = dv_q;
	assign digest_word  = dw_q;
	assign word_index   = wi_q;
	assign last_word    = lw_q;

endmodule

// ===== rtl/sha256s_core.sv =====
// -----------------------------------------------------------------------------
// sha256s_core
// Block window and round unit: a 16-word window that takes bytes big-endian
// and rolls the message schedule, and one SHA-256 round applied per cycle.
// -----------------------------------------------------------------------------
module sha256s_core (
	input  logic                    clk,
	input  sha256s_pkg::core_ctrl_t ctrl,
	input  sha256s_pkg::hash_t      hash,
	output sha256s_pkg::hash_t      vars
);

	sha256s_pkg::word_t w_q [16];
	sha256s_pkg::hash_t v_q;

	sha256s_pkg::word_t w_next;
	sha256s_pkg::word_t t1;
	sha256s_pkg::word_t t2;

	function automatic sha256s_pkg::word_t bsig0(input sha256s_pkg::word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic sha256s_pkg::word_t bsig1(input sha256s_pkg::word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic sha256s_pkg::word_t ssig0(input sha256s_pkg::word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic sha256s_pkg::word_t ssig1(input sha256s_pkg::word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	// Next schedule word from the fixed taps of the window.
	assign w_next = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];

	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha256s_pkg::ROUND_KEY[ctrl.rnd] + w_q[0];
	assign t2 = bsig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], ctrl.byte_val};
		end else if (ctrl.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= hash;
		end else if (ctrl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign vars = v_q;

endmodule

// ===== rtl/sha256s_chk.sv =====
// -----------------------------------------------------------------------------
// sha256s_chk
// Port-level checks on the SHA-256 stream hasher, bound to the top level.
// -----------------------------------------------------------------------------
module sha256s_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_stall,
	input logic        digest_valid,
	input logic        digest_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// The end marker sits on word seven and nowhere else.
	a_last_on_seven: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word does not match word_index");

	// Digest words follow each other with no gap and in order.
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_stall && !last_word |=>
			digest_valid && (word_index == $past(word_index) + 3'd1))
		else $error("digest words out of order or gapped");

	// No new request is taken while earlier digest words are still pending.
	a_busy_in_digest: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !last_word |-> byte_stall)
		else $error("input taken while digest words pending");

	// A stalled digest word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_stall |=>
			digest_valid && $stable(digest_word) && $stable(word_index))
		else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher_top sha256s_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_stall   (byte_stall),
	.digest_valid (digest_valid),
	.digest_stall (digest_stall),
	.digest_word  (digest_word),
	.word_index   (word_index),
	.last_word    (last_word)
);

// ===== tb/sha256_digest_checker.sv =====
// -----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the SHA-256 stream hasher. Hashes every accepted
// request with its own SHA-256 model and compares the digest words in order.
// -----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	input  logic        digest_valid,
	input  logic        digest_stall,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_words,
	output int          words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef sha256s_pkg::word_t word_t;

	typedef struct packed {
		word_t      word;
		logic [2:0] idx;
		logic       last;
	} digest_entry_t;

	localparam word_t IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	word_t         chain [8];
	word_t         sched [16];
	logic [5:0]    fill;
	logic [63:0]   msg_bits;
	digest_entry_t pending_digests [$];
	int            mismatches;
	int            checked;

	function automatic word_t ror(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic run_compression();
		word_t v [8];
		word_t t1, t2, s0, s1, w2, w15;
		int    i, r, j;
		for (i = 0; i < 8; i++)
			v[i] = chain[i];
		for (r = 0; r < 64; r++) begin
			j = r % 16;
			if (r >= 16) begin
				w2  = sched[(r - 2) % 16];
				w15 = sched[(r - 15) % 16];
				s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
				s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
				sched[j] = s1 + sched[(r - 7) % 16] + s0 + sched[j];
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + sched[j];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endtask

	// Big-endian packing; the first byte of a word clears it.
	task automatic pack_byte(input logic [7:0] b);
		int slot;
		int sh;
		slot = int'(fill[5:2]);
		sh   = (3 - int'(fill[1:0])) * 8;
		if (fill[1:0] == 2'd0)
			sched[slot] = '0;
		sched[slot] = sched[slot] | (word_t'(b) << sh);
		fill = fill + 6'd1;
	endtask

	task automatic absorb_request(input logic [7:0] b, input logic hb, input logic lst);
		logic spill;
		int   i;
		if (hb) begin
			pack_byte(b);
			msg_bits = msg_bits + 64'd8;
			if (fill == 6'd0)
				run_compression();
		end
		if (lst) begin
			// Pad: 0x80, zeros to the length slot, one extra block on a long tail.
			spill = (fill >= 6'd56);
			pack_byte(8'h80);
			while (fill != 6'd0 && (spill || fill < 6'd56))
				pack_byte(8'h00);
			if (spill) begin
				run_compression();
				while (fill < 6'd56)
					pack_byte(8'h00);
			end
			sched[14] = msg_bits[63:32];
			sched[15] = msg_bits[31:0];
			fill = '0;
			run_compression();
			for (i = 0; i < 8; i++)
				pending_digests.push_back('{word: chain[i], idx: 3'(i), last: (i == 7)});
			chain    = IV;
			msg_bits = '0;
		end
	endtask

	task automatic check_word();
		digest_entry_t want;
		checked++;
		if (pending_digests.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected digest word %08h index %0d last %0b",
					$realtime, digest_word, word_index, last_word);
			return;
		end
		want = pending_digests.pop_front();
		if (digest_word !== want.word || word_index !== want.idx || last_word !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: digest mismatch: expected %08h/%0d/%0b, got %08h/%0d/%0b",
					$realtime, want.word, want.idx, want.last,
					digest_word, word_index, last_word);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain    = IV;
			for (int i = 0; i < 16; i++)
				sched[i] = '0;
			fill     = '0;
			msg_bits = '0;
			pending_digests.delete();
			mismatches = 0;
			checked    = 0;
			fail_count    <= 0;
			pending_words <= 0;
			words_checked <= 0;
		end else begin
			if (digest_valid && !digest_stall)
				check_word();
			if (byte_valid && !byte_stall)
				absorb_request(data_byte, has_byte, is_last);
			fail_count    <= mismatches;
			pending_words <= pending_digests.size();
			words_checked <= checked;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// -----------------------------------------------------------------------------
// tb_top
// Regression for the SHA-256 stream hasher: directed corner messages, then
// random messages with random idling on both channels, checked word by word.
// -----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 410;
	// Longest quiet stretch of a correct run is a spilled tail (two blocks of
	// padding and rounds) plus a full idle gap; allow plenty.
	localparam int WATCHDOG_LIMIT = 2000;
	// Settle time after the last digest word before the verdict.
	localparam int DRAIN_CYCLES   = 20;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        byte_valid   = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte    = 8'h00;
	logic        has_byte     = 1'b0;
	logic        is_last      = 1'b0;
	logic        digest_valid;
	logic        digest_stall = 1'b1;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int fail_count;
	int pending_words;
	int words_checked;

	// Stimulus bookkeeping for the summary and the stop condition.
	int requests_sent = 0;
	int noops_sent    = 0;
	int bytes_sent    = 0;
	int messages_sent = 0;
	int idle_cycles   = 0;

	// Calm phases: draw no idle cycles on that side for a while.
	bit in_calm  = 1'b0;
	bit out_calm = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sha256_stream_hasher_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.is_last      (is_last),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	sha256_digest_checker digest_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.data_byte     (data_byte),
		.has_byte      (has_byte),
		.is_last       (is_last),
		.digest_valid  (digest_valid),
		.digest_stall  (digest_stall),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word),
		.fail_count    (fail_count),
		.pending_words (pending_words),
		.words_checked (words_checked)
	);

	// Drive one request: idle a random number of cycles with junk on the
	// payload, then hold the request until a rising edge with byte_stall low.
	// Valid stays high across back-to-back requests (one assignment per step).
	task automatic push_request(input logic [7:0] b, input logic hb, input logic lst);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 31) == 0)
			in_calm = ~in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			data_byte  <= 8'($urandom);
			has_byte   <= 1'($urandom);
			is_last    <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		has_byte   <= hb;
		is_last    <= lst;
		do @(posedge clk); while (byte_stall);
		if (hb || lst)
			requests_sent++;
		else
			noops_sent++;
		if (hb)
			bytes_sent++;
		if (lst)
			messages_sent++;
	endtask

	// Drop valid and hold until every expected digest word has been taken.
	task automatic hold_off();
		@(negedge clk);
		byte_valid <= 1'b0;
		do @(posedge clk); while (pending_words != 0);
	endtask

	// One message of random bytes; the end rides on the last byte or comes
	// alone. Sprinkle requests that carry neither byte nor end.
	task automatic send_message(input int len, input bit fused_end);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				push_request(8'($urandom), 1'b0, 1'b0);
			push_request(8'($urandom_range(0, 255)), 1'b1,
				(fused_end && i == len - 1) ? 1'b1 : 1'b0);
		end
		if (!fused_end || len == 0)
			push_request(8'($urandom), 1'b0, 1'b1);
	endtask

	// Favor short messages and lengths around the pad and block boundaries.
	function automatic int pick_length();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 10)
			return $urandom_range(0, 12);
		if (sel < 17) begin
			case ($urandom_range(0, 7))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				6: return 119;
				default: return 120;
			endcase
		end
		return $urandom_range(0, 130);
	endfunction

	// Output side: stall a random number of cycles before each digest word,
	// then take it at the first rising edge where it is valid.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 31) == 0)
				out_calm = ~out_calm;
			gap = out_calm ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				digest_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			digest_stall <= 1'b0;
			do @(posedge clk); while (!digest_valid);
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (digest_valid && !digest_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", idle_cycles);
				$display("sha256_stream_hasher_top regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int directed_count;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Empty message: end alone, junk on the ignored byte.
		push_request(8'hff, 1'b0, 1'b1);
		// Request with neither byte nor end, then another empty message.
		push_request(8'h5a, 1'b0, 1'b0);
		push_request(8'h00, 1'b0, 1'b1);
		// Three bytes, the end riding on the last.
		push_request(8'h61, 1'b1, 1'b0);
		push_request(8'h62, 1'b1, 1'b0);
		push_request(8'h63, 1'b1, 1'b1);
		// Single extreme bytes, fused end and separate end.
		push_request(8'h00, 1'b1, 1'b1);
		push_request(8'hff, 1'b1, 1'b0);
		push_request(8'h00, 1'b0, 1'b1);
		// Walk the byte extremes and a few bit patterns, end alone.
		push_request(8'h00, 1'b1, 1'b0);
		push_request(8'hff, 1'b1, 1'b0);
		push_request(8'h80, 1'b1, 1'b0);
		push_request(8'h7f, 1'b1, 1'b0);
		push_request(8'h01, 1'b1, 1'b0);
		push_request(8'hfe, 1'b1, 1'b0);
		push_request(8'haa, 1'b1, 1'b0);
		push_request(8'h55, 1'b1, 1'b0);
		push_request(8'h00, 1'b0, 1'b1);
		// Hold input until every digest so far has drained.
		hold_off();
		directed_count = requests_sent;

		// Random messages: long tails, exact blocks and multi-block inputs.
		while (requests_sent < directed_count + RANDOM_ITEMS) begin
			send_message(pick_length(), 1'($urandom));
			if ($urandom_range(0, 3) == 0)
				hold_off();
		end

		hold_off();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d messages, %0d message bytes, %0d idle requests",
			messages_sent, bytes_sent, noops_sent);
		$display("compared %0d digest words, %0d mismatches", words_checked, fail_count);
		if (fail_count == 0)
			$display("sha256_stream_hasher_top regression: pass");
		else
			$display("sha256_stream_hasher_top regression: fail");
		$finish;
	end

endmodule
